/* rtl/esa_pkg.sv */
// Package for the error statistics accumulator: widths, constants, shared types.
// Used by every module under rtl except esa_div; depends on nothing.
package esa_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned ABS_W = 31;
    localparam int unsigned REL_W = 32;
    localparam int unsigned DEFAULT_MAX_SAMPLES = 1048576;
    localparam int unsigned IN_DATA_W = 128;
    localparam int unsigned OUT_DATA_W = 320;
    localparam int unsigned OUT_USER_W = 1;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        logic [ABS_W-1:0]    angle_err;
        logic [ABS_W-1:0]    rate_err;
        logic [SAMPLE_W-1:0] angle_den;
        logic [SAMPLE_W-1:0] rate_den;
        logic                last;
    } esa_item_t;

    function automatic logic [ABS_W-1:0] abs_sat(input logic signed [SAMPLE_W-1:0] a,
                                                input logic signed [SAMPLE_W-1:0] b);
        logic signed [SAMPLE_W:0] d;
        logic [SAMPLE_W:0] m;
        d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
        m = d[SAMPLE_W] ? (~d + 1'b1) : d;
        abs_sat = (m > {2'b0, {ABS_W{1'b1}}}) ? {ABS_W{1'b1}} : m[ABS_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] denom(input logic signed [SAMPLE_W-1:0] r,
                                                 input logic [ABS_W-1:0] fl);
        logic [SAMPLE_W-1:0] m;
        logic [SAMPLE_W-1:0] f;
        m = r[SAMPLE_W-1] ? (~r + 1'b1) : r;
        f = (fl == '0) ? SAMPLE_W'(1) : {1'b0, fl};
        // The most negative reference gives the magnitude 2^31, which still fits.
        denom = (m > f) ? m : f;
    endfunction

endpackage

/* rtl/error_statistics_accumulator_top.sv */
// Top level of the error statistics accumulator.
// Depends on esa_pkg, esa_front, esa_back and esa_div.
//
// Each input beat carries a simulated and a reference angle and rate (signed
// Q8.24); each output beat gives the saturated absolute errors, and on the
// beat marked last also the run's maxima and means of absolute and relative
// (Q16.16) error, after which all statistics clear. Relative errors divide by
// max(|reference|, relative_floor). Everything passes through one shared
// radix-2 divider, which loads its operands and then forms one quotient bit
// per cycle for a 52-bit dividend: two divisions per beat and four more for
// the means on the last beat of a run. The back end takes one beat at a
// time: it divides for the angle, then for the rate, updates the statistics
// and, on a last beat, divides for the four means before it loads the
// output register. A two-entry queue sits between the front end and the
// back end, and the output register lets the back end work on the next
// beat while a result waits; the back end stalls only when its next result
// is ready and the previous one is still held. The floor register must only
// be written while the block is idle; a written zero acts as one.
module error_statistics_accumulator_top #(
    parameter int unsigned MAX_SAMPLES = esa_pkg::DEFAULT_MAX_SAMPLES
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [esa_pkg::ABS_W-1:0]       cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sim_angle, ref_angle, sim_rate, ref_rate
    input  logic [esa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // angle_error, rate_error, angle_max_error, angle_mean_error,
    // angle_max_relative, angle_mean_relative, rate_max_error,
    // rate_mean_error, rate_max_relative, rate_mean_relative, zero pad
    output logic [esa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // stats_valid
    output logic [esa_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import esa_pkg::*;

    logic [ABS_W-1:0] floor_reg;
    logic             q_valid, q_ready;
    esa_item_t        q_item;
    logic             user;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) floor_reg <= ABS_W'(1);
        else if (cfg_we) floor_reg <= cfg_wdata;
    end

    esa_front u_front
    (
        .clk(clk), .rst_n(rst_n), .relative_floor(floor_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata), .in_last(s_axis_tlast),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    esa_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_user(user)
    );

    assign m_axis_tuser = user;
endmodule

/* rtl/esa_front.sv */
// Front end: takes input beats, forms absolute errors and divisors and queues them for the back end.
// Depends on esa_pkg.
module esa_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [esa_pkg::ABS_W-1:0]      relative_floor,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [esa_pkg::IN_DATA_W-1:0]  in_data,
    input  logic                           in_last,
    output logic                           q_valid,
    input  logic                           q_ready,
    output esa_pkg::esa_item_t             q_item
);
    import esa_pkg::*;

    // Two-entry queue toward the back end.
    esa_item_t mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, rd_reg;
    esa_item_t  item;
    logic       push, pop;

    always_comb
    begin
        item.angle_err = abs_sat(in_data[31:0], in_data[63:32]);
        item.rate_err  = abs_sat(in_data[95:64], in_data[127:96]);
        item.angle_den = denom(in_data[63:32], relative_floor);
        item.rate_den  = denom(in_data[127:96], relative_floor);
        item.last      = in_last;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rd_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
        end
    end
endmodule

/* rtl/esa_div.sv */
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing; widths come from parameters.
module esa_div #(
    parameter int unsigned NUM_W = 52,
    parameter int unsigned DEN_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int unsigned CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [CW-1:0]    n_reg;
    logic             busy_reg;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   df;

    assign sh   = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign df   = sh - {1'b0, d_reg};
    assign quo  = q_reg;
    assign done = busy_reg && (n_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            n_reg    <= CW'(NUM_W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            n_reg <= n_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg && (n_reg != '0))
        begin
            if (!df[DEN_W])
            begin
                r_reg <= df;
                q_reg <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= sh;
                q_reg <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end
endmodule

/* rtl/esa_back.sv */
// Back end: relative errors, running statistics, means and the output register.
// Depends on esa_pkg and esa_div.
module esa_back #(
    parameter int unsigned MAX_SAMPLES = esa_pkg::DEFAULT_MAX_SAMPLES
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  esa_pkg::esa_item_t              q_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [esa_pkg::OUT_DATA_W-1:0]  out_data,
    output logic                            out_user
);
    import esa_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SA_W = 51;
    localparam int unsigned SR_W = 52;
    localparam int unsigned DEN_W = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DA    = 11'b00000000010,
        S_DR    = 11'b00000000100,
        S_ACC   = 11'b00000001000,
        S_MS    = 11'b00000010000,
        S_M0    = 11'b00000100000,
        S_M1    = 11'b00001000000,
        S_M2    = 11'b00010000000,
        S_M3    = 11'b00100000000,
        S_CLR   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    esa_item_t it_reg;
    logic [REL_W-1:0] ar_reg, rr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ABS_W-1:0] amax_reg, rmax_reg, amean_reg, rmean_reg;
    logic [REL_W-1:0] armax_reg, rrmax_reg, armean_reg, rrmean_reg;
    logic [SA_W-1:0]  asum_reg, rsum_reg;
    logic [SR_W-1:0]  arsum_reg, rrsum_reg;
    logic             ov_reg;
    logic [OUT_DATA_W-1:0] od_reg;
    logic             ou_reg;
    logic             out_load;

    logic             dstart, ddone;
    logic [SR_W-1:0]  dnum, dquo;
    logic [DEN_W-1:0] dden;
    logic [REL_W-1:0] rel_sat;

    esa_div #(.NUM_W(SR_W), .DEN_W(DEN_W)) u_div
    (
        .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
        .done(ddone), .quo(dquo)
    );

    assign rel_sat = (dquo[SR_W-1:REL_W] != '0) ? {REL_W{1'b1}} : dquo[REL_W-1:0];
    assign q_ready = (state_reg == S_IDLE);
    // The output register takes a new result when it is empty or as the previous one leaves.
    assign out_load  = (state_reg == S_OUT) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_user  = ou_reg;

    function automatic logic [SA_W-1:0] add_a(input logic [SA_W-1:0] s,
                                             input logic [ABS_W-1:0] e);
        logic [SA_W:0] t;
        t = {1'b0, s} + (SA_W+1)'(e);
        add_a = t[SA_W] ? {SA_W{1'b1}} : t[SA_W-1:0];
    endfunction

    function automatic logic [SR_W-1:0] add_r(input logic [SR_W-1:0] s,
                                             input logic [REL_W-1:0] e);
        logic [SR_W:0] t;
        t = {1'b0, s} + (SR_W+1)'(e);
        add_r = t[SR_W] ? {SR_W{1'b1}} : t[SR_W-1:0];
    endfunction

    always_comb
    begin
        dstart = 1'b0;
        dnum = '0;
        dden = DEN_W'(cnt_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                dstart = q_valid && q_ready;
                dnum = SR_W'({q_item.angle_err, 16'h0});
                dden = DEN_W'(q_item.angle_den);
            end
            S_DA:
            begin
                dstart = ddone;
                dnum = SR_W'({it_reg.rate_err, 16'h0});
                dden = DEN_W'(it_reg.rate_den);
            end
            S_MS:
            begin
                dstart = 1'b1;
                dnum = SR_W'(asum_reg);
            end
            S_M0:
            begin
                dstart = ddone;
                dnum = arsum_reg;
            end
            S_M1:
            begin
                dstart = ddone;
                dnum = SR_W'(rsum_reg);
            end
            S_M2:
            begin
                dstart = ddone;
                dnum = rrsum_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid && q_ready) state_next = S_DA;
            S_DA:   if (ddone) state_next = S_DR;
            S_DR:   if (ddone) state_next = S_ACC;
            S_ACC:  state_next = it_reg.last ? S_MS : S_OUT;
            S_MS:   state_next = S_M0;
            S_M0:   if (ddone) state_next = S_M1;
            S_M1:   if (ddone) state_next = S_M2;
            S_M2:   if (ddone) state_next = S_M3;
            S_M3:   if (ddone) state_next = S_OUT;
            S_OUT:  if (out_load) state_next = it_reg.last ? S_CLR : S_IDLE;
            S_CLR:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            amax_reg  <= '0;
            rmax_reg  <= '0;
            armax_reg <= '0;
            rrmax_reg <= '0;
            asum_reg  <= '0;
            rsum_reg  <= '0;
            arsum_reg <= '0;
            rrsum_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            if (out_load) ov_reg <= 1'b1;
            if (state_reg == S_ACC)
            begin
                if (it_reg.angle_err > amax_reg) amax_reg <= it_reg.angle_err;
                if (it_reg.rate_err > rmax_reg) rmax_reg <= it_reg.rate_err;
                if (ar_reg > armax_reg) armax_reg <= ar_reg;
                if (rr_reg > rrmax_reg) rrmax_reg <= rr_reg;
                if (cnt_reg < CNT_W'(MAX_SAMPLES))
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    asum_reg  <= add_a(asum_reg, it_reg.angle_err);
                    rsum_reg  <= add_a(rsum_reg, it_reg.rate_err);
                    arsum_reg <= add_r(arsum_reg, ar_reg);
                    rrsum_reg <= add_r(rrsum_reg, rr_reg);
                end
            end
            if (state_reg == S_CLR)
            begin
                cnt_reg   <= '0;
                amax_reg  <= '0;
                rmax_reg  <= '0;
                armax_reg <= '0;
                rrmax_reg <= '0;
                asum_reg  <= '0;
                rsum_reg  <= '0;
                arsum_reg <= '0;
                rrsum_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid && q_ready) it_reg <= q_item;
        if (state_reg == S_DA && ddone) ar_reg <= rel_sat;
        if (state_reg == S_DR && ddone) rr_reg <= rel_sat;
        if (state_reg == S_M0 && ddone)
            amean_reg <= (dquo[SR_W-1:ABS_W] != '0) ? {ABS_W{1'b1}} : dquo[ABS_W-1:0];
        if (state_reg == S_M1 && ddone) armean_reg <= rel_sat;
        if (state_reg == S_M2 && ddone)
            rmean_reg <= (dquo[SR_W-1:ABS_W] != '0) ? {ABS_W{1'b1}} : dquo[ABS_W-1:0];
        if (state_reg == S_M3 && ddone) rrmean_reg <= rel_sat;
        if (out_load)
        begin
            ou_reg <= it_reg.last;
            if (it_reg.last)
                od_reg <= {6'h0, rrmean_reg, rrmax_reg, rmean_reg, rmax_reg,
                           armean_reg, armax_reg, amean_reg, amax_reg,
                           it_reg.rate_err, it_reg.angle_err};
            else
                od_reg <= {258'h0, it_reg.rate_err, it_reg.angle_err};
        end
    end
endmodule
